// ===== sv/utterance_text_normalizer_assert.svh =====
// Assertion macros for the utterance text normalizer.
// Used by the top level only; no other dependencies.
`ifndef UTTERANCE_TEXT_NORMALIZER_ASSERT_SVH
`define UTTERANCE_TEXT_NORMALIZER_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every rising edge, off while reset is low
`define UTN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("utn: assertion failed");
// Property checked on every rising edge, reset included
`define UTN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("utn: reset assertion failed");
`else
`define UTN_ASSERT(lbl, clk, rst_n, prop)
`define UTN_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/utn_pkg.sv =====
// Shared constants, types and byte decoding for the utterance text normalizer.
// No dependencies; imported by every module of the block.
package utn_pkg;

    // Word buffer geometry
    localparam int WORD_MAX = 63;
    localparam int CNT_W    = $clog2(WORD_MAX + 1);
    localparam int ADDR_W   = $clog2(WORD_MAX);

    // Byte codes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_EXCL   = 8'h21;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    // Controller sequence
    typedef enum logic [1:0] {
        S_IDLE,
        S_PROC,
        S_FLUSH,
        S_END
    } t_state;

    // Byte class seen outside a comment
    typedef enum logic [2:0] {
        CLS_DROP,
        CLS_SPACE,
        CLS_HASH,
        CLS_HYPHEN,
        CLS_WHITE,
        CLS_STORE
    } t_cls;

    // Word memory access for one cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // One result item
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       line_end;
        logic       ovf;
    } t_result;

    // Output queue status seen by the controller
    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } t_fifo_stat;

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic t_cls classify(input logic [7:0] c);
        t_cls cls;
        unique case (c) inside
            CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
            CH_COLON, CH_SEMI, CH_QUEST, CH_EXCL, CH_NL: cls = CLS_DROP;
            CH_COMMA, CH_BSLASH:                          cls = CLS_SPACE;
            CH_HASH:                                      cls = CLS_HASH;
            CH_HYPHEN:                                    cls = CLS_HYPHEN;
            default:                                      cls = is_white(c) ? CLS_WHITE
                                                                            : CLS_STORE;
        endcase
        return cls;
    endfunction

endpackage

// ===== sv/utn_word_ram.sv =====
// Word buffer memory: one write port, one read port, registered read data.
// Depends on utn_pkg for depth and the request struct.
module utn_word_ram
    import utn_pkg::*;
(
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [WORD_MAX];
    logic [7:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/utn_out_fifo.sv =====
// Two-entry output queue that decouples result transfers from the flush reads.
// Depends on utn_pkg for the result and status structs.
module utn_out_fifo
    import utn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_push_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_data,
    output t_fifo_stat o_stat
);

    t_result    r_data [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_valid = (r_count != 2'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_data[r_rptr];

    assign o_stat.count = r_count;
    assign o_stat.pop   = w_pop;

    // Storage; the controller never pushes into a full queue
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_push_data;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== sv/utn_ctrl.sv =====
// Sequencer: decodes input bytes, keeps word count and flags, drives the word
// memory and streams flushed words into the output queue. Depends on utn_pkg.
module utn_ctrl
    import utn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_in_char,
    input  logic       i_line_end,
    output logic       o_ready,
    output t_mem_req   o_mem_req,
    input  logic [7:0] i_rdata,
    output logic       o_push,
    output t_result    o_push_data,
    input  t_fifo_stat i_fifo_stat
);

    t_state            r_state, n_state;
    logic [7:0]        r_ch, n_ch;
    logic              r_end, n_end;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_cmt, n_cmt;
    logic              r_hyph, n_hyph;
    logic              r_ovf, n_ovf;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_fl_end, n_fl_end;
    logic [7:0]        r_lead, n_lead;
    logic              r_pend, n_pend;
    logic              r_pend_last, n_pend_last;
    logic              r_pend_ovf, n_pend_ovf;

    logic              w_room;
    logic              w_marker;
    logic              w_full;
    t_cls              w_cls;

    // Queue has a slot for a read issued now (counts the read already in flight)
    assign w_room = ({1'b0, i_fifo_stat.count} + {2'b0, r_pend})
                    <= (3'd1 + {2'b0, i_fifo_stat.pop});
    assign w_full = (r_cnt >= CNT_W'(WORD_MAX));
    assign w_cls  = classify(r_ch);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cmt   <= 1'b0;
            r_hyph  <= 1'b0;
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cmt   <= n_cmt;
            r_hyph  <= n_hyph;
            r_ovf   <= n_ovf;
            r_pend  <= n_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ch        <= n_ch;
        r_end       <= n_end;
        r_idx       <= n_idx;
        r_fl_end    <= n_fl_end;
        r_lead      <= n_lead;
        r_pend_last <= n_pend_last;
        r_pend_ovf  <= n_pend_ovf;
    end

    // Next state and memory requests
    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_end       = r_end;
        n_cnt       = r_cnt;
        n_cmt       = r_cmt;
        n_hyph      = r_hyph;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_fl_end    = r_fl_end;
        n_lead      = r_lead;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_pend_ovf  = r_pend_ovf;
        o_ready     = 1'b0;
        o_mem_req   = '0;
        w_marker    = 1'b0;

        unique case (r_state)
            // Take a byte and settle a hyphen left by the previous byte
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_ch    = i_in_char;
                    n_end   = i_line_end;
                    n_state = S_PROC;
                    if (r_hyph) begin
                        n_hyph = 1'b0;
                        if (is_white(i_in_char)) begin
                            // hyphen then whitespace: partial word becomes one space
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = '0;
                            o_mem_req.wdata = CH_SPACE;
                            n_cnt           = CNT_W'(1);
                            n_ovf           = 1'b0;
                        end else if (!w_full) begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = r_cnt[ADDR_W-1:0];
                            o_mem_req.wdata = CH_HYPHEN;
                            n_cnt           = r_cnt + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
            end

            // Act on the byte
            S_PROC: begin
                n_state = r_end ? S_END : S_IDLE;
                if (r_cmt) begin
                    if (r_ch == CH_HASH) begin
                        n_cmt = 1'b0;
                    end
                end else begin
                    case (w_cls)
                        CLS_DROP: begin
                        end
                        CLS_SPACE, CLS_WHITE: begin
                            n_lead   = (w_cls == CLS_SPACE) ? CH_SPACE : r_ch;
                            n_idx    = '0;
                            n_fl_end = 1'b0;
                            n_state  = S_FLUSH;
                        end
                        CLS_HASH: begin
                            n_cmt = 1'b1;
                        end
                        CLS_HYPHEN: begin
                            // last byte of the line: hyphen is kept as is
                            if (!r_end) begin
                                n_hyph = 1'b1;
                            end else if (!w_full) begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = r_cnt[ADDR_W-1:0];
                                o_mem_req.wdata = CH_HYPHEN;
                                n_cnt           = r_cnt + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        default: begin
                            if (!w_full) begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = r_cnt[ADDR_W-1:0];
                                o_mem_req.wdata = ((r_ch >= CH_LC_A) && (r_ch <= CH_LC_Z))
                                                  ? (r_ch - CASE_OFS) : r_ch;
                                n_cnt           = r_cnt + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    endcase
                end
            end

            // Read out entries 0..count-1, one per cycle while the queue has room
            S_FLUSH: begin
                if (r_idx == r_cnt) begin
                    n_ovf = 1'b0;
                    if (r_fl_end) begin
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end else begin
                        // whitespace becomes the new lead byte
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = '0;
                        o_mem_req.wdata = r_lead;
                        n_cnt           = CNT_W'(1);
                        n_state         = r_end ? S_END : S_IDLE;
                    end
                end else if (w_room) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = r_idx[ADDR_W-1:0];
                    n_pend          = 1'b1;
                    n_pend_last     = r_fl_end && (r_idx == (r_cnt - CNT_W'(1)));
                    n_pend_ovf      = r_ovf;
                    n_idx           = r_idx + CNT_W'(1);
                end
            end

            // End of line: close any comment, flush or send an empty end marker.
            // An empty buffer here means nothing was sent for this line.
            S_END: begin
                n_cmt = 1'b0;
                if (r_cnt == '0) begin
                    if (w_room) begin
                        w_marker = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_idx    = '0;
                    n_fl_end = 1'b1;
                    n_state  = S_FLUSH;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Queue push: flushed byte returning from memory, or the end marker
    always_comb begin
        o_push = r_pend || w_marker;
        if (r_pend) begin
            o_push_data.ch       = i_rdata;
            o_push_data.valid    = 1'b1;
            o_push_data.line_end = r_pend_last;
            o_push_data.ovf      = r_pend_ovf;
        end else begin
            o_push_data.ch       = 8'h00;
            o_push_data.valid    = 1'b0;
            o_push_data.line_end = 1'b1;
            o_push_data.ovf      = 1'b0;
        end
    end

endmodule

// ===== sv/utterance_text_normalizer.sv =====
// Utterance text normalizer, top level.
// Input channel: one text byte per transfer (i_in_char, i_line_end on the last
// byte of a line), i_valid / o_ready. Output channel: cleaned bytes
// (o_out_char, o_char_valid, o_out_line_end, o_word_overflow), o_valid /
// i_ready. Bytes of the current word sit in a 63-entry word memory and are
// sent when whitespace or the line end flushes the buffer; a line that yields
// nothing gives one end marker with o_char_valid low.
// A new byte is taken only in S_IDLE and acted on in S_PROC, and a line end
// adds a pass through S_END. A flush reads the word memory one entry per cycle
// while the receiver keeps up; the single read port sets that rate. Flushed
// bytes go from S_FLUSH through the registered read port into the output
// queue, and an end marker is pushed from S_END.
// A two-entry output queue holds results; when the receiver stalls, flush
// reads pause and the next input is taken only after the current byte is done.
// Reset (synchronous, active low) clears the sequencer, the word count, the
// comment, hyphen and overflow flags, and empties the output queue; the word
// memory needs no clearing since only entries below the count are read.
module utterance_text_normalizer
    import utn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_line_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_out_line_end,
    output logic       o_word_overflow
);

`include "utterance_text_normalizer_assert.svh"

    t_mem_req   w_mem_req;
    logic [7:0] w_rdata;
    logic       w_push;
    t_result    w_push_data;
    t_result    w_head;
    t_fifo_stat w_fifo_stat;
    logic       w_marker;

    // Word memory
    utn_word_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    // Sequencer
    utn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in_char   (i_in_char),
        .i_line_end  (i_line_end),
        .o_ready     (o_ready),
        .o_mem_req   (w_mem_req),
        .i_rdata     (w_rdata),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_fifo_stat (w_fifo_stat)
    );

    // Output queue
    utn_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (w_head),
        .o_stat      (w_fifo_stat)
    );

    assign o_out_char      = w_head.ch;
    assign o_char_valid    = w_head.valid;
    assign o_out_line_end  = w_head.line_end;
    assign o_word_overflow = w_head.ovf;

    // Empty end marker offered at the output
    assign w_marker = o_valid && !o_char_valid;

    // An empty marker always closes its line and carries no byte or flag
    `UTN_ASSERT(a_marker_ends_line, i_clk, i_rst_n, w_marker |-> o_out_line_end)
    `UTN_ASSERT(a_marker_clean, i_clk, i_rst_n, w_marker |-> {o_out_char, o_word_overflow} == '0)
    // A taken byte drops o_ready while the sequencer acts on it
    `UTN_ASSERT(a_two_cycle_min, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)
    // Reset empties the output queue
    `UTN_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

// ===== tb/sv/utterance_text_normalizer_tb.sv =====
// Testbench for the utterance text normalizer: directed and random text lines,
// checked transfer by transfer against a behavioral predictor of the cleaner.
// Depends on utn_pkg and the utterance_text_normalizer top level.
module utterance_text_normalizer_tb;
    import utn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_BYTES = 70;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 300000;

    // One text byte waiting to be sent
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_byte;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_in_char    = 8'h41;
    logic       i_line_end   = 1'b0;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_char_valid;
    logic       o_out_line_end;
    logic       o_word_overflow;

    t_text_byte text_q[$];
    t_text_byte tx_next;
    logic [7:0] line_buf[$];
    t_result    clean_due[$];
    t_result    due_item;

    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    logic       rx_hold     = 1'b0;
    int         bytes_sent  = 0;
    int         errors      = 0;
    int         cycle_count = 0;
    int         total_bytes;

    logic [7:0] punct_set[11] = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_COLON,
                                  CH_SEMI, CH_QUEST, CH_EXCL, CH_NL, CH_COMMA, CH_BSLASH};

    // Predictor state: lead byte plus current word, and the three flags
    logic [7:0] word_buf[WORD_MAX];
    int         word_len    = 0;
    logic       in_comment  = 1'b0;
    logic       hyphen_wait = 1'b0;
    logic       bytes_lost  = 1'b0;
    int         step_count;

    utterance_text_normalizer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_char       (i_in_char),
        .i_line_end      (i_line_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_char      (o_out_char),
        .o_char_valid    (o_char_valid),
        .o_out_line_end  (o_out_line_end),
        .o_word_overflow (o_word_overflow)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic logic white_byte(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic void keep_byte(logic [7:0] c);
        if (word_len < WORD_MAX) begin
            word_buf[word_len] = c;
            word_len++;
        end else begin
            bytes_lost = 1'b1;
        end
    endfunction

    // Send lead and word, all tagged with the overflow flag of this word
    function automatic void flush_word();
        for (int i = 0; i < word_len; i++) begin
            clean_due.push_back('{ch: word_buf[i], valid: 1'b1, line_end: 1'b0,
                                  ovf: bytes_lost});
            step_count++;
        end
        word_len   = 0;
        bytes_lost = 1'b0;
    endfunction

    function automatic void start_lead(logic [7:0] c);
        flush_word();
        word_buf[0] = c;
        word_len    = 1;
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        if (in_comment) begin
            if (c == CH_HASH) in_comment = 1'b0;
            return;
        end
        case (c)
            CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
            CH_COLON, CH_SEMI, CH_QUEST, CH_EXCL, CH_NL: ;
            CH_COMMA, CH_BSLASH: start_lead(CH_SPACE);
            CH_HASH:             in_comment  = 1'b1;
            CH_HYPHEN:           hyphen_wait = 1'b1;
            default: begin
                if (white_byte(c))                      start_lead(c);
                else if (c >= CH_LC_A && c <= CH_LC_Z)  keep_byte(c - CASE_OFS);
                else                                    keep_byte(c);
            end
        endcase
    endfunction

    // Expected output transfers caused by one input transfer
    function automatic void normalize_byte(logic [7:0] c, logic last);
        t_result tail;
        step_count = 0;
        // A pending hyphen: whitespace wipes the partial word, else it is kept
        if (hyphen_wait) begin
            hyphen_wait = 1'b0;
            if (white_byte(c)) begin
                word_buf[0] = CH_SPACE;
                word_len    = 1;
                bytes_lost  = 1'b0;
            end else begin
                keep_byte(CH_HYPHEN);
            end
        end
        scan_byte(c);
        if (last) begin
            if (hyphen_wait) begin
                hyphen_wait = 1'b0;
                keep_byte(CH_HYPHEN);
            end
            flush_word();
            in_comment = 1'b0;
            if (step_count == 0) begin
                clean_due.push_back('{ch: 8'h00, valid: 1'b0, line_end: 1'b0, ovf: 1'b0});
            end
            tail          = clean_due.pop_back();
            tail.line_end = 1'b1;
            clean_due.push_back(tail);
        end
    endfunction

    // ---------------- stimulus building ----------------

    function automatic void commit_line();
        foreach (line_buf[i]) begin
            text_q.push_back('{ch: line_buf[i], last: (i == line_buf.size() - 1)});
        end
        line_buf.delete();
    endfunction

    function automatic logic [7:0] pick_white();
        if ($urandom_range(2) == 0) return CH_SPACE;
        return 8'(CH_TAB + $urandom_range(4));
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = 8'($urandom_range(CH_LC_Z, CH_LC_A));
        return $urandom_range(1) ? c : c - CASE_OFS;
    endfunction

    // A line of random tokens: mostly words and separators, some noise
    function automatic void add_random_line();
        int n_tok;
        int pick;
        int len;
        n_tok = $urandom_range(8, 1);
        for (int t = 0; t < n_tok; t++) begin
            pick = $urandom_range(199);
            if (pick < 90) begin
                len = $urandom_range(7, 1);
                repeat (len) line_buf.push_back(pick_letter());
            end else if (pick < 120) begin
                line_buf.push_back(pick_white());
            end else if (pick < 138) begin
                line_buf.push_back(punct_set[$urandom_range(10)]);
            end else if (pick < 160) begin
                line_buf.push_back(CH_HYPHEN);
                if ($urandom_range(9) < 6) line_buf.push_back(pick_white());
            end else if (pick < 175) begin
                // comment, left open now and then
                line_buf.push_back(CH_HASH);
                len = $urandom_range(3);
                repeat (len) line_buf.push_back(pick_letter());
                if ($urandom_range(3) != 0) line_buf.push_back(CH_HASH);
            end else if (pick < 198) begin
                line_buf.push_back(8'($urandom_range(255, 1)));
            end else begin
                len = $urandom_range(70, 60);
                repeat (len) line_buf.push_back(pick_letter());
            end
        end
        commit_line();
    endfunction

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                normalize_byte(i_in_char, i_line_end);
                bytes_sent++;
            end
            // Input slot free: offer the next byte or idle
            if (!i_valid || o_ready) begin
                if (text_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    tx_next = text_q.pop_front();
                    i_valid    <= 1'b1;
                    i_in_char  <= tx_next.ch;
                    i_line_end <= tx_next.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (clean_due.size() == 0) begin
                    $error("unexpected output transfer: out_char %02h", o_out_char);
                    errors++;
                end else begin
                    due_item = clean_due.pop_front();
                    if (o_out_char !== due_item.ch) begin
                        $error("out_char: expected %02h, got %02h", due_item.ch, o_out_char);
                        errors++;
                    end
                    if (o_char_valid !== due_item.valid) begin
                        $error("char_valid: expected %0b, got %0b", due_item.valid,
                               o_char_valid);
                        errors++;
                    end
                    if (o_out_line_end !== due_item.line_end) begin
                        $error("out_line_end: expected %0b, got %0b", due_item.line_end,
                               o_out_line_end);
                        errors++;
                    end
                    if (o_word_overflow !== due_item.ovf) begin
                        $error("word_overflow: expected %0b, got %0b", due_item.ovf,
                               o_word_overflow);
                        errors++;
                    end
                end
            end
            i_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver stall so the output queue fills and input backs up
    initial begin : rx_backpressure
        while (bytes_sent < 40) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin : stimulus
        // Case folding extremes, comma and backslash to space
        line_buf = '{"a", "z", CH_SPACE, "Z", CH_COMMA, "m", CH_BSLASH, "0"};
        commit_line();
        // Only dropped bytes: empty end marker
        line_buf = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_COLON,
                     CH_SEMI, CH_QUEST, CH_EXCL, CH_NL};
        commit_line();
        // Hyphen rules: delete at line start and mid word, kept before a
        // comment, byte after closing hash processed, hyphen last on the line
        line_buf = '{CH_HYPHEN, CH_TAB, "a", "b", CH_HYPHEN, CH_SPACE, "c", CH_HYPHEN,
                     CH_HASH, "z", CH_HASH, "d", CH_HYPHEN};
        commit_line();
        // Hyphen before a dropped byte is kept
        line_buf = '{"q", CH_HYPHEN, CH_EXCL, "r"};
        commit_line();
        // Unclosed comment ends with the line
        line_buf = '{CH_HASH, "a", "b"};
        commit_line();
        line_buf = '{"e"};
        commit_line();
        // Byte extremes and the other whitespace bytes
        line_buf = '{8'hFF, 8'h01, 8'h80, 8'(CH_TAB + 2), 8'(CH_TAB + 3), CH_CR};
        commit_line();
        // Word one byte longer than the buffer
        repeat (WORD_MAX + 1) line_buf.push_back(pick_letter());
        commit_line();

        total_bytes = text_q.size();
        while (text_q.size() < total_bytes + RANDOM_BYTES) add_random_line();
        total_bytes = text_q.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        tx_idle_pct <= 31;
        rx_idle_pct <= 58;
        while (bytes_sent < total_bytes / 3) @(posedge i_clk);
        tx_idle_pct <= 58;
        rx_idle_pct <= 31;
        while (bytes_sent < 2 * total_bytes / 3) @(posedge i_clk);
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;

        // Drain: every byte sent and every expected transfer seen
        while (text_q.size() != 0 || i_valid || clean_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (clean_due.size() != 0) begin
            $error("%0d expected output transfers never arrived", clean_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
